// File: rtl/ctcg_pkg.sv
// ----------------------------------------------------------------------------
// CTC greedy decoder package
// Field widths, the result word type and the register reset value.
// ----------------------------------------------------------------------------
package ctcg_pkg;

   localparam int SCORE_W = 16;
   localparam int IDX_W   = 13;
   localparam int KEY_W   = 14;

   localparam logic [KEY_W-1:0] KEY_COUNT_RESET = 14'd8192;

   typedef struct packed {
      logic                      emit;
      logic [IDX_W-1:0]          char_index;
      logic signed [SCORE_W-1:0] char_score;
      logic                      last_step;
   } ctcg_rsp_type;

endpackage

// File: rtl/ctc_greedy_decoder.sv
// Each row's result word is held in the row queue, then in the result register.
// Throughput: one score word per cycle unless req_full, set by one row scorer compare.
// A two-entry row queue and the result register let either side stall on its own.
// Reset is synchronous and active high; it clears the row state, previous winner,
// queues, and sets key_count to 8192.
// ----------------------------------------------------------------------------
// CTC greedy decoder
// Greedy CTC decoding of a stream of class scores, one result word per row.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder #(
   parameter int MAX_CLASSES = 8192
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [ctcg_pkg::SCORE_W-1:0] req_class_score,
   input  logic                                req_row_end,
   input  logic                                req_sequence_end,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_emit,
   output logic [ctcg_pkg::IDX_W-1:0]          rsp_char_index,
   output logic signed [ctcg_pkg::SCORE_W-1:0] rsp_char_score,
   output logic                                rsp_last_step,
   input  logic                                csr_wr_en,
   input  logic [ctcg_pkg::KEY_W-1:0]          csr_wr_data
);

   localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int CNT_W = $clog2(MAX_CLASSES + 1);
   localparam int ROW_W = CLS_W + ctcg_pkg::SCORE_W + 1;

   logic [ctcg_pkg::KEY_W-1:0]          key_count_ff;
   logic                                req_accept;
   logic                                row_push, row_last, row_full, row_empty, row_pop;
   logic [CLS_W-1:0]                    row_winner;
   logic signed [ctcg_pkg::SCORE_W-1:0] row_score;
   logic [ROW_W-1:0]                    row_push_data, row_pop_data;
   logic                                rsp_valid;
   ctcg_pkg::ctcg_rsp_type              rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= ctcg_pkg::KEY_COUNT_RESET;
      end else if (csr_wr_en) begin
         key_count_ff <= csr_wr_data;
      end
   end

   assign req_full   = row_full;
   assign req_accept = req_push && !row_full;

   ctcg_front #(
      .MAX_CLASSES(MAX_CLASSES),
      .CLS_W      (CLS_W),
      .CNT_W      (CNT_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .score       (req_class_score),
      .row_end     (req_row_end),
      .sequence_end(req_sequence_end),
      .row_push    (row_push),
      .row_winner  (row_winner),
      .row_score   (row_score),
      .row_last    (row_last)
   );

   assign row_push_data = {row_last, row_score, row_winner};

   ctcg_fifo #(
      .WIDTH(ROW_W)
   ) u_row_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (row_push),
      .push_data(row_push_data),
      .full     (row_full),
      .pop      (row_pop),
      .pop_data (row_pop_data),
      .empty    (row_empty)
   );

   ctcg_back #(
      .CLS_W(CLS_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .key_count (key_count_ff),
      .row_valid (!row_empty),
      .row_winner(row_pop_data[CLS_W-1:0]),
      .row_score (row_pop_data[CLS_W +: ctcg_pkg::SCORE_W]),
      .row_last  (row_pop_data[ROW_W-1]),
      .row_pop   (row_pop),
      .rsp_valid (rsp_valid),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_empty      = !rsp_valid;
   assign rsp_emit       = rsp.emit;
   assign rsp_char_index = rsp.char_index;
   assign rsp_char_score = rsp.char_score;
   assign rsp_last_step  = rsp.last_step;

`ifndef SYNTHESIS
   a_no_char_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_emit) |-> (rsp_char_index == '0 && rsp_char_score == '0))
      else $error("result word without a character carries nonzero fields");

   a_row_queued: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_row_end) |=> !row_empty)
      else $error("row end word did not reach the row queue");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      row_push |-> !row_full)
      else $error("row queue written while full");
`endif

endmodule

// File: rtl/ctcg_fifo.sv
// ----------------------------------------------------------------------------
// CTC greedy decoder row queue
// Two-entry register queue that decouples the row scorer from the emitter.
// ----------------------------------------------------------------------------
module ctcg_fifo #(
   parameter int WIDTH = 30
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/ctcg_front.sv
// ----------------------------------------------------------------------------
// CTC greedy decoder row scorer
// Tracks the running maximum of a row and hands the row winner onward.
// ----------------------------------------------------------------------------
module ctcg_front #(
   parameter int MAX_CLASSES = 8192,
   parameter int CLS_W       = 13,
   parameter int CNT_W       = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic signed [ctcg_pkg::SCORE_W-1:0] score,
   input  logic                               row_end,
   input  logic                               sequence_end,
   output logic                               row_push,
   output logic [CLS_W-1:0]                   row_winner,
   output logic signed [ctcg_pkg::SCORE_W-1:0] row_score,
   output logic                               row_last
);

   logic signed [ctcg_pkg::SCORE_W-1:0] best_score_ff, best_score_in;
   logic [CLS_W-1:0]                    best_class_ff, best_class_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic                                take, update;
   logic [CLS_W-1:0]                    cur_class;

   assign take      = (count_ff < CNT_W'(MAX_CLASSES));
   assign update    = take && ((count_ff == '0) || (score > best_score_ff));
   assign cur_class = count_ff[CLS_W-1:0];

   assign row_push   = accept && row_end;
   assign row_winner = update ? cur_class : best_class_ff;
   assign row_score  = update ? score : best_score_ff;
   assign row_last   = sequence_end;

   always_comb begin
      best_score_in = best_score_ff;
      best_class_in = best_class_ff;
      count_in      = count_ff;
      if (accept) begin
         if (row_end) begin
            best_score_in = '0;
            best_class_in = '0;
            count_in      = '0;
         end else if (take) begin
            count_in = count_ff + CNT_W'(1);
            if (update) begin
               best_score_in = score;
               best_class_in = cur_class;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= '0;
         best_class_ff <= '0;
         count_ff      <= '0;
      end else begin
         best_score_ff <= best_score_in;
         best_class_ff <= best_class_in;
         count_ff      <= count_in;
      end
   end

endmodule

// File: rtl/ctcg_back.sv
// ----------------------------------------------------------------------------
// CTC greedy decoder emitter
// Applies the emit rule to each row winner and holds the result word.
// ----------------------------------------------------------------------------
module ctcg_back #(
   parameter int CLS_W = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ctcg_pkg::KEY_W-1:0]          key_count,
   input  logic                                row_valid,
   input  logic [CLS_W-1:0]                    row_winner,
   input  logic signed [ctcg_pkg::SCORE_W-1:0] row_score,
   input  logic                                row_last,
   output logic                                row_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_pop,
   output ctcg_pkg::ctcg_rsp_type              rsp
);

   localparam int WIDE_W = (CLS_W > ctcg_pkg::KEY_W) ? CLS_W : ctcg_pkg::KEY_W;

   logic                          valid_ff, valid_in;
   logic [ctcg_pkg::IDX_W-1:0]    prev_ff, prev_in;
   ctcg_pkg::ctcg_rsp_type        rsp_ff, rsp_in;
   logic                          load, emit;
   logic [WIDE_W-1:0]             winner_wide, index_wide;

   assign load        = row_valid && (!valid_ff || rsp_pop);
   assign row_pop     = load;
   assign winner_wide = WIDE_W'(row_winner);
   assign index_wide  = winner_wide - WIDE_W'(1);
   assign emit        = (winner_wide != '0) &&
                        (winner_wide < WIDE_W'(key_count)) &&
                        (winner_wide != WIDE_W'(prev_ff));

   always_comb begin
      valid_in = valid_ff;
      prev_in  = prev_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in          = 1'b1;
         prev_in           = row_last ? '0 : winner_wide[ctcg_pkg::IDX_W-1:0];
         rsp_in.emit       = emit;
         rsp_in.char_index = emit ? index_wide[ctcg_pkg::IDX_W-1:0] : '0;
         rsp_in.char_score = emit ? row_score : '0;
         rsp_in.last_step  = row_last;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         prev_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule
